// ===== src/tcpt_pkg.sv =====
// Package for the tiered cache placement table: transaction structs, table row,
// result codes, register indexes and arithmetic widths.
// No dependencies.
package tcpt_pkg;

   localparam int SIZE_W  = 48;
   localparam int KEY_W   = 32;
   localparam int PCT_W   = 7;
   localparam int PROD_W  = 56;   // d*100 and (pct+1)*total both stay below 2^55
   localparam int MPLR_W  = 8;
   localparam int STEP_W  = 3;
   localparam int CSR_W   = 1;

   localparam logic [MPLR_W-1:0] PCT_SCALE = 8'd100;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

   localparam logic [PCT_W-1:0] RAM_PCT_RST = 7'd15;
   localparam logic [PCT_W-1:0] SSD_PCT_RST = 7'd5;

   localparam logic [CSR_W-1:0] CSR_RAM_PCT = 1'b0;
   localparam logic [CSR_W-1:0] CSR_SSD_PCT = 1'b1;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_PLACE  = 1'b1;

   localparam logic [2:0] ACT_READ_HDD    = 3'd0;
   localparam logic [2:0] ACT_READ_RAM    = 3'd1;
   localparam logic [2:0] ACT_SSD_TO_RAM  = 3'd2;
   localparam logic [2:0] ACT_HDD_TO_RAM  = 3'd3;
   localparam logic [2:0] ACT_HDD_TO_SSD  = 3'd4;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [KEY_W-1:0]  file_key;
      logic [SIZE_W-1:0] file_size;
      logic [SIZE_W-1:0] free_ram;
      logic [SIZE_W-1:0] total_ram;
      logic [SIZE_W-1:0] free_ssd;
      logic [SIZE_W-1:0] total_ssd;
   } tcpt_req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] record_status;
   } tcpt_rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
      logic              in_ram;
      logic              in_ssd;
   } tcpt_row_type;

   typedef struct packed {
      logic done;
      logic ok;
   } tcpt_room_res_type;

endpackage

// ===== src/tcpt_room.sv =====
// Free-space test unit: one shared adder does the subtract, two shift-add
// multiplies and the final compare under a small sequencer.
// Depends on tcpt_pkg.
module tcpt_room (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tcpt_pkg::SIZE_W-1:0]   free_b,
   input  logic [tcpt_pkg::SIZE_W-1:0]   total_b,
   input  logic [tcpt_pkg::SIZE_W-1:0]   size_b,
   input  logic [tcpt_pkg::PCT_W-1:0]    pct,
   output tcpt_pkg::tcpt_room_res_type   res
);
   import tcpt_pkg::*;

   localparam logic [2:0] R_IDLE = 3'd0;
   localparam logic [2:0] R_SUB  = 3'd1;
   localparam logic [2:0] R_MUL1 = 3'd2;
   localparam logic [2:0] R_MUL2 = 3'd3;
   localparam logic [2:0] R_CMP  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] p1_ff, p1_in;
   logic [MPLR_W-1:0] mplr_ff, mplr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   tcpt_room_res_type res_ff, res_in;

   logic [PROD_W-1:0] a_op, b_op, acc_next;
   logic              sub_op;
   logic [PROD_W:0]   sum;

   // shared adder; carry out set on subtract means a >= b
   always_comb begin
      a_op   = acc_ff;
      b_op   = mcand_ff;
      sub_op = 1'b0;
      case (state_ff)
         R_SUB: begin
            a_op   = PROD_W'(free_b);
            b_op   = PROD_W'(size_b);
            sub_op = 1'b1;
         end
         R_CMP: begin
            a_op   = p1_ff;
            b_op   = acc_ff;
            sub_op = 1'b1;
         end
         default: begin
            a_op   = acc_ff;
            b_op   = mcand_ff;
            sub_op = 1'b0;
         end
      endcase
      sum = {1'b0, a_op} + {1'b0, (sub_op ? ~b_op : b_op)} + (PROD_W+1)'(sub_op);
   end

   assign acc_next = mplr_ff[0] ? sum[PROD_W-1:0] : acc_ff;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      p1_in    = p1_ff;
      mplr_in  = mplr_ff;
      step_in  = step_ff;
      res_in   = '0;
      case (state_ff)
         R_IDLE: begin
            if (start) state_in = R_SUB;
         end
         R_SUB: begin
            if (total_b == '0 || !sum[PROD_W] || sum[PROD_W-1:0] == '0) begin
               res_in.done = 1'b1;
               res_in.ok   = 1'b0;
               state_in    = R_IDLE;
            end else begin
               mcand_in = sum[PROD_W-1:0];
               acc_in   = '0;
               mplr_in  = PCT_SCALE;
               step_in  = '0;
               state_in = R_MUL1;
            end
         end
         R_MUL1: begin
            acc_in   = acc_next;
            mcand_in = mcand_ff << 1;
            mplr_in  = mplr_ff >> 1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               p1_in    = acc_next;
               acc_in   = '0;
               mcand_in = PROD_W'(total_b);
               mplr_in  = MPLR_W'(pct) + MPLR_W'(1);
               step_in  = '0;
               state_in = R_MUL2;
            end
         end
         R_MUL2: begin
            acc_in   = acc_next;
            mcand_in = mcand_ff << 1;
            mplr_in  = mplr_ff >> 1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) state_in = R_CMP;
         end
         R_CMP: begin
            res_in.done = 1'b1;
            res_in.ok   = sum[PROD_W];
            state_in    = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      p1_ff    <= p1_in;
      mplr_ff  <= mplr_in;
      step_ff  <= step_in;
   end

   assign res = res_ff;

endmodule

// ===== src/tiered_cache_placement_table.sv =====
// Tiered cache placement table top level: record memory, key scan sequencer,
// threshold registers and result register. Depends on tcpt_pkg and tcpt_room.
//
//   port group  | dir | handshake
//   ------------+-----+------------------------------------------------
//   req_*       | in  | taken when start is high and busy is low
//   rsp_*       | out | rsp_valid high for one cycle, cannot be held off
//   csr_*       | in  | written on any cycle with csr_we high
//
// A record transaction scans the keys (one memory row read per cycle during the key
// scan); a placement adds up to two tier tests, RAM then SSD, each run on the shared
// adder in tcpt_room.
// Synchronous reset empties the table at once (entry count to zero).
// The result is registered; busy drops as rsp_valid rises.
module tiered_cache_placement_table #(
   parameter int ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tcpt_pkg::tcpt_req_type      req,
   output logic                        rsp_valid,
   output tcpt_pkg::tcpt_rsp_type      rsp,
   input  logic                        csr_we,
   input  logic [tcpt_pkg::CSR_W-1:0]  csr_index,
   input  logic [tcpt_pkg::PCT_W-1:0]  csr_wdata
);
   import tcpt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_RAM    = 3'd3;
   localparam logic [2:0] S_SSD    = 3'd4;

   logic [2:0]       state_ff, state_in;
   tcpt_req_type     req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             found_ff, found_in;
   logic [PCT_W-1:0] ram_pct_ff, ram_pct_in;
   logic [PCT_W-1:0] ssd_pct_ff, ssd_pct_in;
   logic             room_start_ff, room_start_in;
   logic             tier_ff, tier_in;    // 0 RAM test, 1 SSD test
   logic             rsp_valid_ff, rsp_valid_in;
   tcpt_rsp_type     rsp_ff, rsp_in;

   tcpt_row_type     mem [ENTRIES];
   tcpt_row_type     rd_row_ff;
   logic             mem_re, mem_we;
   logic [IDX_W-1:0] mem_raddr, mem_waddr;
   tcpt_row_type     mem_wdata;

   logic              hit;
   tcpt_room_res_type room_res;

   tcpt_room u_room (
      .clock   (clock),
      .reset   (reset),
      .start   (room_start_ff),
      .free_b  (tier_ff ? req_ff.free_ssd  : req_ff.free_ram),
      .total_b (tier_ff ? req_ff.total_ssd : req_ff.total_ram),
      .size_b  (rd_row_ff.size),
      .pct     (tier_ff ? ssd_pct_ff : ram_pct_ff),
      .res     (room_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_row_ff <= mem[mem_raddr];
   end

   assign hit = chk_valid_ff && (rd_row_ff.key == req_ff.file_key);

   always_comb begin
      ram_pct_in = ram_pct_ff;
      ssd_pct_in = ssd_pct_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RAM_PCT: ram_pct_in = csr_wdata;
            CSR_SSD_PCT: ssd_pct_in = csr_wdata;
            default: begin
               ram_pct_in = ram_pct_ff;
               ssd_pct_in = ssd_pct_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_idx_in    = hit_idx_ff;
      found_in      = found_ff;
      room_start_in = 1'b0;
      tier_in       = tier_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_re        = 1'b0;
      mem_raddr     = scan_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = hit_idx_ff;
      mem_wdata     = rd_row_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one row read issued per cycle, compared the cycle after
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = chk_idx_ff;
               state_in   = S_DECIDE;
            end else if (scan_ff < count_ff) begin
               mem_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end else begin
               found_in = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            if (req_ff.cmd == CMD_RECORD) begin
               rsp_valid_in  = 1'b1;
               rsp_in.action = ACT_READ_HDD;
               if (found_ff) begin
                  rsp_in.record_status = ST_FOUND;
               end else if (count_ff == CNT_W'(ENTRIES)) begin
                  rsp_in.record_status = ST_FULL;
               end else begin
                  mem_we           = 1'b1;
                  mem_waddr        = count_ff[IDX_W-1:0];
                  mem_wdata.key    = req_ff.file_key;
                  mem_wdata.size   = req_ff.file_size;
                  mem_wdata.in_ram = 1'b0;
                  mem_wdata.in_ssd = 1'b0;
                  count_in         = count_ff + CNT_W'(1);
                  rsp_in.record_status = ST_INSERTED;
               end
            end else begin
               rsp_in.record_status = ST_NONE;
               if (!found_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.action = ACT_READ_HDD;
               end else if (rd_row_ff.in_ram) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.action = ACT_READ_RAM;
               end else begin
                  room_start_in = 1'b1;
                  tier_in       = 1'b0;
                  state_in      = S_RAM;
               end
            end
         end
         S_RAM: begin
            if (room_res.done) begin
               if (room_res.ok) begin
                  mem_we           = 1'b1;
                  mem_wdata.in_ram = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_in.action    = rd_row_ff.in_ssd ? ACT_SSD_TO_RAM : ACT_HDD_TO_RAM;
                  state_in         = S_IDLE;
               end else begin
                  room_start_in = 1'b1;
                  tier_in       = 1'b1;
                  state_in      = S_SSD;
               end
            end
         end
         S_SSD: begin
            if (room_res.done) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (room_res.ok) begin
                  mem_we           = 1'b1;
                  mem_wdata.in_ssd = 1'b1;
                  rsp_in.action    = ACT_HDD_TO_SSD;
               end else begin
                  rsp_in.action = ACT_READ_HDD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         room_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ram_pct_ff    <= RAM_PCT_RST;
         ssd_pct_ff    <= SSD_PCT_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_valid_ff  <= chk_valid_in;
         room_start_ff <= room_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         ram_pct_ff    <= ram_pct_in;
         ssd_pct_ff    <= ssd_pct_in;
      end
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
      found_ff   <= found_in;
      tier_ff    <= tier_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== tb/sv/tiered_cache_placement_table_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tiered_cache_placement_table: directed corner cases, then
// random record/placement traffic over several threshold settings, checked by a scoreboard.
// Depends on tcpt_pkg and the RTL top level only.
module tiered_cache_placement_table_tb;
   import tcpt_pkg::*;

   localparam int TABLE_DEPTH     = 64;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int SETTLE_CYCLES   = 120;
   localparam logic [SIZE_W-1:0] MAX48 = '1;

   // Mirror of the placement table; predicts the action/status of each transaction.
   class placement_scoreboard;
      logic [KEY_W-1:0]  keys   [TABLE_DEPTH];
      logic [SIZE_W-1:0] sizes  [TABLE_DEPTH];
      bit                in_ram [TABLE_DEPTH];
      bit                in_ssd [TABLE_DEPTH];
      int                count = 0;
      logic [PCT_W-1:0]  ram_pct = RAM_PCT_RST;
      logic [PCT_W-1:0]  ssd_pct = SSD_PCT_RST;
      tcpt_rsp_type      outstanding[$];
      int                errors = 0;
      int                seen = 0;

      function int lookup(logic [KEY_W-1:0] key);
         for (int i = 0; i < count; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      // free share after the copy must reach at least pct+1 percent, by cross-multiplication
      function bit has_room(logic [SIZE_W-1:0] free_b, logic [SIZE_W-1:0] total_b,
                            logic [SIZE_W-1:0] fsize, logic [PCT_W-1:0] pct);
         logic [63:0] d;
         if (total_b == '0 || free_b <= fsize) return 1'b0;
         d = 64'(free_b) - 64'(fsize);
         return (d * 64'd100) >= ((64'(pct) + 64'd1) * 64'(total_b));
      endfunction

      function void set_threshold(logic [CSR_W-1:0] idx, logic [PCT_W-1:0] val);
         if (idx == CSR_RAM_PCT) ram_pct = val;
         else if (idx == CSR_SSD_PCT) ssd_pct = val;
      endfunction

      function int pending();
         return outstanding.size();
      endfunction

      function void note_request(tcpt_req_type r);
         tcpt_rsp_type e;
         int idx;
         idx = lookup(r.file_key);
         e.action = ACT_READ_HDD;
         e.record_status = ST_NONE;
         if (r.cmd == CMD_RECORD) begin
            if (idx >= 0) begin
               e.record_status = ST_FOUND;
            end else if (count >= TABLE_DEPTH) begin
               e.record_status = ST_FULL;
            end else begin
               keys[count]   = r.file_key;
               sizes[count]  = r.file_size;
               in_ram[count] = 1'b0;
               in_ssd[count] = 1'b0;
               count++;
               e.record_status = ST_INSERTED;
            end
         end else if (idx >= 0) begin
            if (in_ram[idx]) begin
               e.action = ACT_READ_RAM;
            end else if (has_room(r.free_ram, r.total_ram, sizes[idx], ram_pct)) begin
               in_ram[idx] = 1'b1;
               e.action = in_ssd[idx] ? ACT_SSD_TO_RAM : ACT_HDD_TO_RAM;
            end else if (has_room(r.free_ssd, r.total_ssd, sizes[idx], ssd_pct)) begin
               in_ssd[idx] = 1'b1;
               e.action = ACT_HDD_TO_SSD;
            end
         end
         outstanding.push_back(e);
      endfunction

      task flag_mismatch(string msg);
         errors++;
         $display("mismatch @%0t: %s", $time, msg);
      endtask

      task check_result(tcpt_rsp_type got);
         tcpt_rsp_type want;
         seen++;
         if (outstanding.size() == 0) begin
            flag_mismatch($sformatf("result %0d (action %0d status %0d) with none outstanding",
                                    seen, got.action, got.record_status));
            return;
         end
         want = outstanding.pop_front();
         if (got.action !== want.action)
            flag_mismatch($sformatf("result %0d action %0d, want %0d",
                                    seen, got.action, want.action));
         if (got.record_status !== want.record_status)
            flag_mismatch($sformatf("result %0d record_status %0d, want %0d",
                                    seen, got.record_status, want.record_status));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tcpt_req_type     req = '0;
   logic             rsp_valid;
   tcpt_rsp_type     rsp;
   logic             csr_we = 1'b0;
   logic [CSR_W-1:0] csr_index = '0;
   logic [PCT_W-1:0] csr_wdata = '0;
   int               cycle_count = 0;

   placement_scoreboard board = new;

   tiered_cache_placement_table #(.ENTRIES(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL tiered_cache_placement_table");
      $finish;
   end

   // random width 1..48, or all 48 bits random
   function automatic logic [SIZE_W-1:0] rand48(bit full);
      logic [63:0] v;
      logic [63:0] mask;
      v = {$urandom, $urandom};
      mask = full ? 64'(MAX48) : ((64'd1 << $urandom_range(1, SIZE_W)) - 64'd1);
      return SIZE_W'(v & mask);
   endfunction

   function automatic tcpt_req_type build_req(logic cmd, logic [KEY_W-1:0] key,
                                              logic [SIZE_W-1:0] fsize,
                                              logic [SIZE_W-1:0] fr, logic [SIZE_W-1:0] tr,
                                              logic [SIZE_W-1:0] fs, logic [SIZE_W-1:0] ts);
      tcpt_req_type r;
      r.cmd = cmd;
      r.file_key = key;
      r.file_size = fsize;
      r.free_ram = fr;
      r.total_ram = tr;
      r.free_ssd = fs;
      r.total_ssd = ts;
      return r;
   endfunction

   // free/total pair for one tier, often sat right on the threshold edge
   task automatic shape_tier(input logic [SIZE_W-1:0] fsize, input logic [PCT_W-1:0] pct,
                             input bit mostly_fail,
                             output logic [SIZE_W-1:0] fr, output logic [SIZE_W-1:0] tot);
      logic [63:0] need;
      logic [63:0] d;
      logic [63:0] sum;
      int mode;
      int dec;
      mode = $urandom_range(0, 9);
      tot = rand48(1'b0);
      if (mode == 0) begin
         tot = '0;
         fr = rand48(1'b0);
      end else if (mode < 5) begin
         need = ((64'(pct) + 64'd1) * 64'(tot) + 64'd99) / 64'd100;
         if (mostly_fail && $urandom_range(0, 3) != 0) begin
            dec = $urandom_range(1, 2);
            d = (need > 64'(dec)) ? need - 64'(dec) : 64'd0;
         end else begin
            d = need + 64'($urandom_range(0, 1));
         end
         sum = 64'(fsize) + d;
         fr = (sum > 64'(MAX48)) ? rand48(1'b0) : SIZE_W'(sum);
      end else if (mode < 7) begin
         fr = (fsize > 3) ? fsize - SIZE_W'($urandom_range(0, 3)) : fsize;
      end else begin
         fr = rand48(1'b0);
      end
   endtask

   task automatic random_req(output tcpt_req_type r);
      int pick;
      int idx;
      int span;
      logic [SIZE_W-1:0] fsize;
      pick = $urandom_range(0, 99);
      r = build_req(CMD_PLACE, $urandom, rand48(1'b1), rand48(1'b1), rand48(1'b1),
                    rand48(1'b1), rand48(1'b1));
      if (pick < 8 || (pick >= 30 && board.count == 0)) begin
         r.cmd = CMD_RECORD;
         r.file_size = ($urandom_range(0, 4) == 0) ? rand48(1'b0)
                                                   : SIZE_W'($urandom_range(0, 1 << 20));
      end else if (pick < 18 && board.count > 0) begin
         r.cmd = CMD_RECORD;
         r.file_key = board.keys[$urandom_range(0, board.count - 1)];
      end else if (pick < 25) begin
         r.cmd = 1'($urandom_range(0, 1));
      end else if (pick >= 30) begin
         // favour recently inserted entries so they are seen before they land in RAM
         span = (board.count - 1 < 7) ? board.count - 1 : 7;
         idx = $urandom_range(0, 1) ? board.count - 1 - $urandom_range(0, span)
                                    : $urandom_range(0, board.count - 1);
         fsize = board.sizes[idx];
         r.file_key = board.keys[idx];
         shape_tier(fsize, board.ram_pct, 1'b1, r.free_ram, r.total_ram);
         shape_tier(fsize, board.ssd_pct, 1'b0, r.free_ssd, r.total_ssd);
      end
   endtask

   // start stays high from one transaction to the next unless a pause intervenes
   task automatic send(tcpt_req_type r);
      start <= 1'b1;
      req <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic write_thresholds(logic [PCT_W-1:0] ram_val, logic [PCT_W-1:0] ssd_val);
      csr_we <= 1'b1;
      csr_index <= CSR_RAM_PCT;
      csr_wdata <= ram_val;
      @(posedge clock);
      csr_index <= CSR_SSD_PCT;
      csr_wdata <= ssd_val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_threshold(CSR_RAM_PCT, ram_val);
      board.set_threshold(CSR_SSD_PCT, ssd_val);
   endtask

   initial begin
      logic [PCT_W-1:0] ram_set [PHASES];
      logic [PCT_W-1:0] ssd_set [PHASES];
      tcpt_req_type r;

      ram_set = '{7'd0, 7'd100, 7'd127, 7'd127, 7'd0, 7'd99, 7'd0, 7'd0};
      ssd_set = '{7'd0, 7'd100, 7'd127, 7'd0, 7'd127, 7'd1, 7'd0, 7'd0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, thresholds at reset values (RAM 15, SSD 5)
      send(build_req(CMD_PLACE, 32'h0, '0, MAX48, MAX48, MAX48, MAX48));   // empty table
      send(build_req(CMD_RECORD, 32'h0, '0, '0, '0, '0, '0));
      send(build_req(CMD_RECORD, 32'h0, 48'd5, '0, '0, '0, '0));            // size kept
      send(build_req(CMD_RECORD, 32'hFFFF_FFFF, MAX48, MAX48, MAX48, MAX48, MAX48));
      send(build_req(CMD_PLACE, 32'hFFFF_FFFF, '0, MAX48, '0, MAX48, '0));  // zero totals
      send(build_req(CMD_PLACE, 32'hFFFF_FFFF, '0, MAX48, MAX48, MAX48, MAX48));
      send(build_req(CMD_RECORD, 32'd1, 48'd1000, '0, '0, '0, '0));
      send(build_req(CMD_PLACE, 32'd1, '0, 48'd2600, 48'd10000, '0, '0));   // RAM edge, passes
      send(build_req(CMD_PLACE, 32'd1, '0, '0, '0, '0, '0));                // already in RAM
      send(build_req(CMD_RECORD, 32'd2, 48'd100, '0, '0, '0, '0));
      send(build_req(CMD_PLACE, 32'd2, '0, 48'd1699, 48'd10000, 48'd160, 48'd1000));
      send(build_req(CMD_PLACE, 32'd2, '0, 48'd1700, 48'd10000, '0, '0));   // SSD to RAM
      send(build_req(CMD_PLACE, 32'h0, MAX48, '0, MAX48, MAX48, MAX48));
      send(build_req(CMD_PLACE, 32'h0, '0, MAX48, MAX48, '0, '0));
      send(build_req(CMD_PLACE, 32'h1234_5678, '0, MAX48, 48'd1, MAX48, 48'd1)); // unknown key

      ram_set[6] = PCT_W'($urandom_range(0, 127));
      ssd_set[6] = PCT_W'($urandom_range(0, 127));
      ram_set[7] = PCT_W'($urandom_range(0, 100));
      ssd_set[7] = PCT_W'($urandom_range(0, 100));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_thresholds(ram_set[p], ssd_set[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // phase 2 runs back to back with no gaps
            if (p != 2 && $urandom_range(0, 99) < 18) pause($urandom_range(1, 90));
            random_req(r);
            send(r);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.flag_mismatch($sformatf("%0d results never arrived", board.pending()));
      if (board.errors == 0)
         $display("PASS tiered_cache_placement_table");
      else
         $display("FAIL tiered_cache_placement_table");
      $finish;
   end

endmodule
